// File: hdl/kcd_pkg.sv
// ----------------------------------------------------------------------------
// kcd_pkg
// Shared types, constants and the segment decode for the countdown timer.
// ----------------------------------------------------------------------------
package kcd_pkg;

    localparam int NUM_DIGITS_DEF = 3;

    localparam int ACTION_W = 3;
    localparam int DIGIT_W  = 4;
    localparam int SEG_W    = 7;
    localparam int EN_W     = 3;
    localparam int COUNT_W  = 10;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 10'd999;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 10'd1;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 4'd9;

    typedef enum logic [ACTION_W-1:0] {
        ACT_DIGIT     = 3'd0,
        ACT_PROGRAM   = 3'd1,
        ACT_START     = 3'd2,
        ACT_SEC_TICK  = 3'd3,
        ACT_DISP_TICK = 3'd4
    } t_action;

    typedef struct packed {
        logic [COUNT_W-1:0] remaining;
        logic               programming;
        logic               running;
        logic               done;
        logic [SEG_W-1:0]   segments;
        logic [EN_W-1:0]    enables;
    } t_state;

    // bit 0 is segment a
    function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0: s = 7'h3f;
            4'd1: s = 7'h06;
            4'd2: s = 7'h5b;
            4'd3: s = 7'h4f;
            4'd4: s = 7'h66;
            4'd5: s = 7'h6d;
            4'd6: s = 7'h7d;
            4'd7: s = 7'h07;
            4'd8: s = 7'h7f;
            4'd9: s = 7'h67;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

// File: hdl/kcd_digit_split.sv
// ----------------------------------------------------------------------------
// kcd_digit_split
// Splits the count into decimal digits and picks the one shown at a phase.
// ----------------------------------------------------------------------------
module kcd_digit_split #(
    parameter int NUM_DIGITS = kcd_pkg::NUM_DIGITS_DEF,
    parameter int PHASE_W    = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1
) (
    input  logic [kcd_pkg::COUNT_W-1:0] i_remaining,
    input  logic [PHASE_W-1:0]          i_phase,
    output logic [kcd_pkg::SEG_W-1:0]   o_segments,
    output logic [kcd_pkg::EN_W-1:0]    o_enables
);
    import kcd_pkg::*;

    logic [15:0]        prod_h;
    logic [3:0]         hund;
    logic [9:0]         hund_x100;
    logic [6:0]         rest;
    logic [13:0]        prod_t;
    logic [3:0]         tens;
    logic [3:0]         units;
    logic [2:0]         pos;
    logic [DIGIT_W-1:0] sel;

    // count never exceeds 999: x*41>>12 and x*103>>10 give exact /100 and /10
    assign prod_h    = 16'(i_remaining) * 16'd41;
    assign hund      = prod_h[15:12];
    assign hund_x100 = 10'(hund) * 10'd100;
    assign rest      = 7'(i_remaining - hund_x100);
    assign prod_t    = 14'(rest) * 14'd103;
    assign tens      = prod_t[13:10];
    assign units     = 4'(rest - 7'(tens) * 7'd10);

    assign pos = 3'(NUM_DIGITS - 1) - 3'(i_phase);

    always_comb begin
        case (pos)
            3'd0:    sel = units;
            3'd1:    sel = tens;
            3'd2:    sel = hund;
            default: sel = '0;
        endcase
    end

    assign o_segments = seg_decode(sel);
    assign o_enables  = (32'(i_phase) < EN_W) ? EN_W'(1 << i_phase) : '0;

endmodule

// File: hdl/kcd_step.sv
// ----------------------------------------------------------------------------
// kcd_step
// Next-state logic for one event: entry, start, countdown and display scan.
// ----------------------------------------------------------------------------
module kcd_step #(
    parameter int NUM_DIGITS = kcd_pkg::NUM_DIGITS_DEF,
    parameter int PHASE_W    = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1
) (
    input  kcd_pkg::t_state                i_state,
    input  logic [PHASE_W-1:0]             i_entry_phase,
    input  logic [PHASE_W-1:0]             i_disp_phase,
    input  logic [kcd_pkg::ACTION_W-1:0]   i_action,
    input  logic [kcd_pkg::DIGIT_W-1:0]    i_digit,
    output kcd_pkg::t_state                o_state,
    output logic [PHASE_W-1:0]             o_entry_phase,
    output logic [PHASE_W-1:0]             o_disp_phase
);
    import kcd_pkg::*;

    localparam logic [PHASE_W:0] LAST_PHASE = (PHASE_W + 1)'(NUM_DIGITS - 1);

    logic [PHASE_W-1:0] entry_eff;
    logic [PHASE_W-1:0] disp_eff;
    logic [PHASE_W-1:0] entry_inc;
    logic [PHASE_W-1:0] disp_inc;
    logic [13:0]        acc;
    logic [SEG_W-1:0]   disp_seg;
    logic [EN_W-1:0]    disp_en;

    assign entry_eff = ({1'b0, i_entry_phase} > LAST_PHASE) ? '0 : i_entry_phase;
    assign disp_eff  = ({1'b0, i_disp_phase}  > LAST_PHASE) ? '0 : i_disp_phase;
    assign entry_inc = ({1'b0, entry_eff} == LAST_PHASE) ? '0 : PHASE_W'(entry_eff + 1'b1);
    assign disp_inc  = ({1'b0, disp_eff}  == LAST_PHASE) ? '0 : PHASE_W'(disp_eff + 1'b1);

    assign acc = (14'(i_state.remaining) << 3) + (14'(i_state.remaining) << 1)
               + 14'(i_digit);

    kcd_digit_split #(
        .NUM_DIGITS (NUM_DIGITS),
        .PHASE_W    (PHASE_W)
    ) u_split (
        .i_remaining (i_state.remaining),
        .i_phase     (disp_eff),
        .o_segments  (disp_seg),
        .o_enables   (disp_en)
    );

    always_comb begin
        o_state       = i_state;
        o_entry_phase = i_entry_phase;
        o_disp_phase  = i_disp_phase;
        case (t_action'(i_action))
            ACT_DIGIT: begin
                if (i_state.programming && (i_digit <= DIGIT_MAX)) begin
                    if (entry_eff == '0) begin
                        o_state.remaining = COUNT_W'(i_digit);
                    end else if (acc > 14'(COUNT_MAX)) begin
                        o_state.remaining = COUNT_MAX;
                    end else begin
                        o_state.remaining = acc[COUNT_W-1:0];
                    end
                    o_entry_phase = entry_inc;
                end
            end
            ACT_PROGRAM: begin
                o_state.programming = 1'b1;
                o_state.running     = 1'b0;
                o_state.done        = 1'b0;
            end
            ACT_START: begin
                if (i_state.programming) begin
                    o_state.programming = 1'b0;
                    o_state.running     = 1'b1;
                end
            end
            ACT_SEC_TICK: begin
                if (i_state.running && !i_state.done) begin
                    if (i_state.remaining == '0) begin
                        o_state.done    = 1'b1;
                        o_state.running = 1'b0;
                        o_state.enables = '0;
                    end else begin
                        o_state.remaining = i_state.remaining - 1'b1;
                    end
                end
            end
            ACT_DISP_TICK: begin
                if (i_state.running && !i_state.done) begin
                    o_state.segments = disp_seg;
                    o_state.enables  = disp_en;
                    o_disp_phase     = disp_inc;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: hdl/keypad_countdown_timer_display.sv
// ----------------------------------------------------------------------------
// keypad_countdown_timer_display
// Countdown timer with keypad entry and multiplexed seven-segment scan.
// Pipeline: 2 register stages (input reg, state reg); o_valid rises once an accepted item has passed both.
// Throughput: one item per cycle unless i_ready stalls the output; the state update is a single pass.
// Reset: synchronous active low; count 1, all flags, phases, segments and enables clear; r_action and r_digit keep.
// ----------------------------------------------------------------------------
module keypad_countdown_timer_display #(
    parameter int NUM_DIGITS = kcd_pkg::NUM_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [kcd_pkg::ACTION_W-1:0]  i_action,
    input  logic [kcd_pkg::DIGIT_W-1:0]   i_digit,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [kcd_pkg::SEG_W-1:0]     o_segments,
    output logic [kcd_pkg::EN_W-1:0]      o_digit_enable,
    output logic                          o_programming_led,
    output logic                          o_finished,
    output logic [kcd_pkg::COUNT_W-1:0]   o_count_value
);
    import kcd_pkg::*;

    localparam int PHASE_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    logic                r_in_valid;
    logic [ACTION_W-1:0] r_action;
    logic [DIGIT_W-1:0]  r_digit;
    logic                r_out_valid;
    t_state              r_state;
    t_state              n_state;
    logic [PHASE_W-1:0]  r_entry_phase;
    logic [PHASE_W-1:0]  n_entry_phase;
    logic [PHASE_W-1:0]  r_disp_phase;
    logic [PHASE_W-1:0]  n_disp_phase;
    logic                advance;

    assign advance = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_action <= i_action;
            r_digit  <= i_digit;
        end
    end

    kcd_step #(
        .NUM_DIGITS (NUM_DIGITS),
        .PHASE_W    (PHASE_W)
    ) u_step (
        .i_state       (r_state),
        .i_entry_phase (r_entry_phase),
        .i_disp_phase  (r_disp_phase),
        .i_action      (r_action),
        .i_digit       (r_digit),
        .o_state       (n_state),
        .o_entry_phase (n_entry_phase),
        .o_disp_phase  (n_disp_phase)
    );

    // state registers double as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid       <= 1'b0;
            r_state.remaining <= COUNT_RESET;
            r_state.programming <= 1'b0;
            r_state.running   <= 1'b0;
            r_state.done      <= 1'b0;
            r_state.segments  <= '0;
            r_state.enables   <= '0;
            r_entry_phase     <= '0;
            r_disp_phase      <= '0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state       <= n_state;
                r_entry_phase <= n_entry_phase;
                r_disp_phase  <= n_disp_phase;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_segments        = r_state.segments;
    assign o_digit_enable    = r_state.enables;
    assign o_programming_led = r_state.programming;
    assign o_finished        = r_state.done;
    assign o_count_value     = r_state.remaining;

endmodule

// File: hdl/kcd_checker.sv
// ----------------------------------------------------------------------------
// kcd_assertions
// Port-level checks for the countdown timer, bound to the top level.
// ----------------------------------------------------------------------------
module kcd_assertions (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [kcd_pkg::EN_W-1:0]      o_digit_enable,
    input logic                          o_programming_led,
    input logic                          o_finished,
    input logic [kcd_pkg::COUNT_W-1:0]   o_count_value
);
    import kcd_pkg::*;

    a_en_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_digit_enable))
        else $error("digit enable not one-hot");

    a_done_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_finished |-> (o_digit_enable == '0))
        else $error("enables active after finish");

    a_prog_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_programming_led && o_finished))
        else $error("programming and finished both set");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_count_value <= COUNT_MAX)
        else $error("count above maximum");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_count_value)))
        else $error("stalled result changed");

endmodule

bind keypad_countdown_timer_display kcd_assertions u_kcd_assertions (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_digit_enable    (o_digit_enable),
    .o_programming_led (o_programming_led),
    .o_finished        (o_finished),
    .o_count_value     (o_count_value)
);

// File: test/kcd_checker.sv
// ----------------------------------------------------------------------------
// kcd_checker
// Watches both channels of the countdown timer, predicts the display state
// for each accepted event item and compares every accepted result against it.
// ----------------------------------------------------------------------------
module kcd_checker #(
    parameter int NUM_DIGITS = kcd_pkg::NUM_DIGITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    input  logic                         i_req_ready,
    input  logic [kcd_pkg::ACTION_W-1:0] i_action,
    input  logic [kcd_pkg::DIGIT_W-1:0]  i_digit,
    input  logic                         i_rsp_valid,
    input  logic                         i_rsp_ready,
    input  logic [kcd_pkg::SEG_W-1:0]    i_segments,
    input  logic [kcd_pkg::EN_W-1:0]     i_digit_enable,
    input  logic                         i_programming_led,
    input  logic                         i_finished,
    input  logic [kcd_pkg::COUNT_W-1:0]  i_count_value,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked,
    output int                           o_expired
);
    import kcd_pkg::*;

    typedef struct packed {
        logic [SEG_W-1:0]   segments;
        logic [EN_W-1:0]    enables;
        logic               prog;
        logic               done;
        logic [COUNT_W-1:0] count;
    } t_display;

    localparam logic [SEG_W-1:0] SEG_LUT [10] = '{
        7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h67
    };

    t_display           expected_displays [$];
    logic [COUNT_W-1:0] count_r;
    int                 entry_ph;
    int                 scan_ph;
    logic               prog_r;
    logic               run_r;
    logic               done_r;
    logic [SEG_W-1:0]   seg_r;
    logic [EN_W-1:0]    en_r;
    int                 fail_cnt    = 0;
    int                 checked_cnt = 0;
    int                 expired_cnt = 0;
    int                 pending_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;
    assign o_checked    = checked_cnt;
    assign o_expired    = expired_cnt;

    task automatic load_key(input logic [DIGIT_W-1:0] d);
        int p;
        int acc;
        p = (entry_ph >= NUM_DIGITS) ? 0 : entry_ph;
        if (p == 0) begin
            acc = int'(d);
        end else begin
            acc = int'(count_r) * 10 + int'(d);
            if (acc > int'(COUNT_MAX)) begin
                acc = int'(COUNT_MAX);
            end
        end
        count_r = acc[COUNT_W-1:0];
        p++;
        entry_ph = (p >= NUM_DIGITS) ? 0 : p;
    endtask

    task automatic scan_next();
        int p;
        int place;
        int d;
        p = (scan_ph >= NUM_DIGITS) ? 0 : scan_ph;
        place = 1;
        for (int i = 0; i < NUM_DIGITS - 1 - p; i++) begin
            place *= 10;
        end
        d = (int'(count_r) / place) % 10;
        en_r = EN_W'((1 << p) & 7);
        seg_r = SEG_LUT[d];
        p++;
        scan_ph = (p >= NUM_DIGITS) ? 0 : p;
    endtask

    task automatic advance_timer(input logic [ACTION_W-1:0] a, input logic [DIGIT_W-1:0] d);
        case (a)
            ACT_DIGIT: begin
                if (prog_r && d <= DIGIT_MAX) begin
                    load_key(d);
                end
            end
            ACT_PROGRAM: begin
                prog_r = 1'b1;
                run_r  = 1'b0;
                done_r = 1'b0;
            end
            ACT_START: begin
                if (prog_r) begin
                    prog_r = 1'b0;
                    run_r  = 1'b1;
                end
            end
            ACT_SEC_TICK: begin
                if (run_r && !done_r) begin
                    if (count_r == '0) begin
                        done_r = 1'b1;
                        run_r  = 1'b0;
                        en_r   = '0;
                        expired_cnt++;
                    end else begin
                        count_r = count_r - 1'b1;
                    end
                end
            end
            ACT_DISP_TICK: begin
                if (run_r && !done_r) begin
                    scan_next();
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_display got;
        t_display want;
        t_display nxt;
        if (!i_rst_n) begin
            count_r  = COUNT_RESET;
            entry_ph = 0;
            scan_ph  = 0;
            prog_r   = 1'b0;
            run_r    = 1'b0;
            done_r   = 1'b0;
            seg_r    = '0;
            en_r     = '0;
            expected_displays.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                got = '{i_segments, i_digit_enable, i_programming_led, i_finished,
                        i_count_value};
                if (expected_displays.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %h", $time, got);
                    fail_cnt++;
                end else begin
                    want = expected_displays.pop_front();
                    checked_cnt++;
                    check_field("segments", 16'(want.segments), 16'(got.segments));
                    check_field("digit_enable", 16'(want.enables), 16'(got.enables));
                    check_field("programming_led", 16'(want.prog), 16'(got.prog));
                    check_field("finished", 16'(want.done), 16'(got.done));
                    check_field("count_value", 16'(want.count), 16'(got.count));
                end
            end
            if (i_req_valid && i_req_ready) begin
                advance_timer(i_action, i_digit);
                nxt = '{seg_r, en_r, prog_r, done_r, count_r};
                expected_displays.push_back(nxt);
            end
        end
        pending_cnt = expected_displays.size();
    end

endmodule

// File: test/keypad_countdown_timer_display_tb.sv
// ----------------------------------------------------------------------------
// keypad_countdown_timer_display_tb
// Drives event items into the countdown timer: a directed pass over the
// special cases, then program/enter/start/countdown sequences with random
// content and noise under several idle and stall mixes, including one long
// output hold-off. Checking is done by kcd_checker.
// ----------------------------------------------------------------------------
module keypad_countdown_timer_display_tb;
    import kcd_pkg::*;

    localparam int RUN_LIMIT   = 400000;
    localparam int PHASE_ITEMS = 350;

    logic                i_clk             = 1'b0;
    logic                i_rst_n           = 1'b0;
    logic                i_valid           = 1'b0;
    logic [ACTION_W-1:0] i_action          = '0;
    logic [DIGIT_W-1:0]  i_digit           = '0;
    logic                i_ready           = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [SEG_W-1:0]    o_segments;
    logic [EN_W-1:0]     o_digit_enable;
    logic                o_programming_led;
    logic                o_finished;
    logic [COUNT_W-1:0]  o_count_value;

    int   fail_count;
    int   pending;
    int   checked;
    int   expired;
    int   item_cnt     = 0;
    int   cycle_cnt    = 0;
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    logic hold_rx      = 1'b0;

    keypad_countdown_timer_display u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_digit          (i_digit),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_segments       (o_segments),
        .o_digit_enable   (o_digit_enable),
        .o_programming_led(o_programming_led),
        .o_finished       (o_finished),
        .o_count_value    (o_count_value)
    );

    kcd_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_ready      (o_ready),
        .i_action         (i_action),
        .i_digit          (i_digit),
        .i_rsp_valid      (o_valid),
        .i_rsp_ready      (i_ready),
        .i_segments       (o_segments),
        .i_digit_enable   (o_digit_enable),
        .i_programming_led(o_programming_led),
        .i_finished       (o_finished),
        .i_count_value    (o_count_value),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_expired        (expired)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results pending", cycle_cnt, pending);
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_rx) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_item(input logic [ACTION_W-1:0] a, input logic [DIGIT_W-1:0] d);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= a;
        i_digit  <= d;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        item_cnt++;
    endtask

    // program, key in a count, start, then let it run with ticks and noise
    task automatic run_countdown();
        int                 n_keys;
        int                 n_ticks;
        int                 r;
        logic [DIGIT_W-1:0] d;
        send_item(ACT_PROGRAM, DIGIT_W'($urandom_range(15)));
        n_keys = ($urandom_range(9) < 7) ? NUM_DIGITS_DEF : $urandom_range(0, 5);
        for (int k = 0; k < n_keys; k++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                d = DIGIT_W'($urandom_range(10, 15));
            end else if ((k == 0 && r < 80) || (k == 1 && r < 40)) begin
                d = '0;
            end else begin
                d = DIGIT_W'($urandom_range(9));
            end
            send_item(ACT_DIGIT, d);
        end
        send_item(ACT_START, DIGIT_W'($urandom_range(15)));
        n_ticks = $urandom_range(4, 130);
        for (int t = 0; t < n_ticks; t++) begin
            r = $urandom_range(99);
            d = DIGIT_W'($urandom_range(15));
            if (r < 45) begin
                send_item(ACT_SEC_TICK, d);
            end else if (r < 92) begin
                send_item(ACT_DISP_TICK, d);
            end else if (r < 97) begin
                send_item(ACTION_W'($urandom_range(7)), d);
            end else begin
                send_item(ACT_PROGRAM, d);
            end
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct);
        int first;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        first = item_cnt;
        while (item_cnt - first < PHASE_ITEMS) begin
            run_countdown();
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle timer, ignored keys and buttons, unknown actions
        send_item(ACT_SEC_TICK, 4'd0);
        send_item(ACT_DISP_TICK, 4'd0);
        send_item(ACT_DIGIT, 4'd5);
        send_item(ACT_START, 4'd0);
        send_item(3'd5, 4'd15);
        send_item(3'd6, 4'd0);
        send_item(3'd7, 4'd15);
        // largest count, out-of-range key ignored
        send_item(ACT_PROGRAM, 4'd0);
        send_item(ACT_DIGIT, 4'd15);
        send_item(ACT_DIGIT, 4'd9);
        send_item(ACT_DIGIT, 4'd9);
        send_item(ACT_DIGIT, 4'd9);
        send_item(ACT_START, 4'd0);
        send_item(ACT_DISP_TICK, 4'd0);
        send_item(ACT_DISP_TICK, 4'd0);
        send_item(ACT_DISP_TICK, 4'd0);
        send_item(ACT_SEC_TICK, 4'd0);
        // program while running, then run out from one
        send_item(ACT_PROGRAM, 4'd0);
        send_item(ACT_DIGIT, 4'd0);
        send_item(ACT_DIGIT, 4'd0);
        send_item(ACT_DIGIT, 4'd1);
        send_item(ACT_START, 4'd0);
        send_item(ACT_SEC_TICK, 4'd0);
        send_item(ACT_SEC_TICK, 4'd0);
        send_item(ACT_DISP_TICK, 4'd0);

        fork
            begin
                repeat (20) @(posedge i_clk);
                hold_rx <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_rx <= 1'b0;
            end
        join_none
        run_phase(0, 0);
        run_phase(72, 0);
        run_phase(0, 72);
        run_phase(31, 31);
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        $display("Sent %0d event items under four idle/stall mixes with a long output stall",
                 item_cnt);
        $display("Compared %0d results; the count ran out %0d times", checked, expired);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
